[rtl/bsa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsa_pkg: shared types and constants
// Item types of the sorter channels and the request format that runs from
// the front part to the back part.
// ----------------------------------------------------------------------------
package bsa_pkg;

  localparam int MAX_ELEMENTS_DEF = 16;
  localparam int VALUE_W          = 32;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last_in;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] sorted_value;
    logic                      last_out;
    logic                      overflowed;
  } out_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      store;
    logic                      last;
    logic                      ovf;
  } cmd_t;

endpackage

[rtl/bsa_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsa_front: request classifier
// Counts the values of the current set, decides whether each one is kept or
// dropped and forwards a request with the running overflow state.
// ----------------------------------------------------------------------------
module bsa_front #(
  parameter int MAX_ELEMENTS = bsa_pkg::MAX_ELEMENTS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  bsa_pkg::in_item_t in_item,
  output logic             cmd_push,
  input  logic             cmd_full,
  output bsa_pkg::cmd_t    cmd
);
  import bsa_pkg::*;

  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  logic             accept;

  assign full     = cmd_full;
  assign accept   = push && !cmd_full;
  assign cmd_push = accept;

  always_comb begin
    cmd.value = in_item.value;
    cmd.last  = in_item.last_in;
    cmd.store = (count_r < CNT_W'(MAX_ELEMENTS));
    cmd.ovf   = ovf_r || !cmd.store;
  end

  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    if (accept) begin
      if (in_item.last_in) begin
        count_nxt = '0;
        ovf_nxt   = 1'b0;
      end else begin
        count_nxt = count_r + CNT_W'(cmd.store);
        ovf_nxt   = cmd.ovf;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

[rtl/bsa_cmd_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsa_cmd_fifo: request queue
// Two-entry queue that decouples the classifier from the sorting engine.
// ----------------------------------------------------------------------------
module bsa_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  bsa_pkg::cmd_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output bsa_pkg::cmd_t rd_data,
  output logic          empty
);
  import bsa_pkg::*;

  cmd_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_wr, do_rd;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_wr;
    rd_ptr_nxt = rd_ptr_r ^ do_rd;
    cnt_nxt    = cnt_r + 2'(do_wr) - 2'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

[rtl/bsa_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsa_back: sorting engine
// Keeps the set in a memory in ascending order by insertion, one
// compare-and-shift step at a time, and streams it out at the end of a set.
// ----------------------------------------------------------------------------
module bsa_back #(
  parameter int MAX_ELEMENTS = bsa_pkg::MAX_ELEMENTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_empty,
  input  bsa_pkg::cmd_t     cmd,
  output logic              cmd_pop,
  output logic              empty,
  input  logic              pop,
  output bsa_pkg::out_item_t out_item
);
  import bsa_pkg::*;

  localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
  localparam int ADDR_W = $clog2(MAX_ELEMENTS);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_INS_RD  = 3'd1;
  localparam logic [2:0] ST_INS_CMP = 3'd2;
  localparam logic [2:0] ST_INS_PUT = 3'd3;
  localparam logic [2:0] ST_EMIT_RD = 3'd4;
  localparam logic [2:0] ST_EMIT_LD = 3'd5;

  logic signed [VALUE_W-1:0] mem [MAX_ELEMENTS];
  logic signed [VALUE_W-1:0] rdata_r;

  logic [2:0]                state_r, state_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]         j_r, j_nxt;
  logic [ADDR_W-1:0]         k_r, k_nxt;
  logic signed [VALUE_W-1:0] val_r, val_nxt;
  logic                      last_r, last_nxt;
  logic                      ovf_r, ovf_nxt;
  out_item_t                 out_r, out_nxt;
  logic                      out_valid_r, out_valid_nxt;

  logic                      we, re;
  logic [ADDR_W-1:0]         waddr, raddr;
  logic signed [VALUE_W-1:0] wdata;
  logic [ADDR_W-1:0]         top_idx;
  logic                      out_free;

  assign empty    = !out_valid_r;
  assign out_item = out_r;
  assign top_idx  = ADDR_W'(cnt_r - CNT_W'(1));
  assign out_free = !out_valid_r || pop;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    val_nxt       = val_r;
    last_nxt      = last_r;
    ovf_nxt       = ovf_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !pop;
    cmd_pop       = 1'b0;
    we            = 1'b0;
    re            = 1'b0;
    waddr         = j_r + ADDR_W'(1);
    wdata         = val_r;
    raddr         = j_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop  = 1'b1;
          val_nxt  = cmd.value;
          last_nxt = cmd.last;
          ovf_nxt  = cmd.ovf;
          k_nxt    = '0;
          if (cmd.store && cnt_r == '0) begin
            we        = 1'b1;
            waddr     = '0;
            wdata     = cmd.value;
            cnt_nxt   = CNT_W'(1);
            state_nxt = cmd.last ? ST_EMIT_RD : ST_IDLE;
          end else if (cmd.store) begin
            j_nxt     = top_idx;
            state_nxt = ST_INS_RD;
          end else begin
            state_nxt = cmd.last ? ST_EMIT_RD : ST_IDLE;
          end
        end
      end
      ST_INS_RD: begin
        re        = 1'b1;
        state_nxt = ST_INS_CMP;
      end
      ST_INS_CMP: begin
        we = 1'b1;
        if (rdata_r > val_r) begin
          wdata = rdata_r;
          if (j_r == '0) begin
            state_nxt = ST_INS_PUT;
          end else begin
            j_nxt     = j_r - ADDR_W'(1);
            state_nxt = ST_INS_RD;
          end
        end else begin
          cnt_nxt   = cnt_r + CNT_W'(1);
          state_nxt = last_r ? ST_EMIT_RD : ST_IDLE;
        end
      end
      ST_INS_PUT: begin
        we        = 1'b1;
        waddr     = '0;
        cnt_nxt   = cnt_r + CNT_W'(1);
        state_nxt = last_r ? ST_EMIT_RD : ST_IDLE;
      end
      ST_EMIT_RD: begin
        re        = 1'b1;
        raddr     = k_r;
        state_nxt = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        if (out_free) begin
          out_valid_nxt        = 1'b1;
          out_nxt.sorted_value = rdata_r;
          out_nxt.last_out     = (k_r == top_idx);
          out_nxt.overflowed   = ovf_r;
          if (k_r == top_idx) begin
            cnt_nxt   = '0;
            state_nxt = ST_IDLE;
          end else begin
            k_nxt     = k_r + ADDR_W'(1);
            state_nxt = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    j_r    <= j_nxt;
    k_r    <= k_nxt;
    val_r  <= val_nxt;
    last_r <= last_nxt;
    ovf_r  <= ovf_nxt;
    out_r  <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/bubble_sort_ascending.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bubble_sort_ascending: stable ascending sorter of signed 32-bit sets
// Collects a set of values up to last_in, sorts it stably in ascending order
// and returns it as a stream of results, the final one marked by last_out.
// ----------------------------------------------------------------------------
// Values are kept sorted in a single-port-write, single-port-read memory as
// they arrive. The first value of a set is written straight to the front and
// a dropped value writes nothing. Any other value is compared with the stored
// values from the top down: each larger one shifts one place up, and the
// value is written above the first one not larger, or at the front. At the end
// of a set each result is one memory read and one load of the output register,
// which waits until that register is free or popped. A two-entry request queue
// lets the next set start arriving while the current one is still being placed
// or emitted. Values past MAX_ELEMENTS in a set are dropped and every result of
// that set has overflowed set.
module bubble_sort_ascending #(
  parameter int MAX_ELEMENTS = bsa_pkg::MAX_ELEMENTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  bsa_pkg::in_item_t  in_item,
  output logic               empty,
  input  logic               pop,
  output bsa_pkg::out_item_t out_item
);
  import bsa_pkg::*;

  cmd_t fe_cmd;
  cmd_t be_cmd;
  logic fe_push;
  logic q_full;
  logic q_empty;
  logic be_pop;

  bsa_front #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .cmd_push(fe_push),
    .cmd_full(q_full),
    .cmd     (fe_cmd)
  );

  bsa_cmd_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (fe_push),
    .wr_data(fe_cmd),
    .full   (q_full),
    .rd_en  (be_pop),
    .rd_data(be_cmd),
    .empty  (q_empty)
  );

  bsa_back #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_empty(q_empty),
    .cmd      (be_cmd),
    .cmd_pop  (be_pop),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule
